### hw/rtl/rgm_pkg.sv
// Shared constants, types and helpers for the region green-mean block.
`default_nettype none
package rgm_pkg;

  // Geometry and sizing
  localparam int NUM_REGIONS   = 8;
  localparam int COORD_BITS    = 10;
  localparam int WINDOW_BITS   = 4 * COORD_BITS;
  localparam int AREA_BITS     = 2 * COORD_BITS;
  localparam int REG_IDX_BITS  = 3;
  localparam int REGION_BITS   = 3;

  // Pixel format
  localparam int PIXEL_BITS    = 16;
  localparam int PIX_POS_BITS  = 10;
  localparam int GREEN_SHIFT   = 5;
  localparam int GREEN_BITS    = 6;

  // Arithmetic
  localparam int SUM_BITS      = 26;
  localparam int MEAN_BITS     = 14;
  localparam int FRAC_BITS     = 8;
  localparam int SAT_SHIFT     = MEAN_BITS - FRAC_BITS;
  localparam int STEP_BITS     = $clog2(MEAN_BITS + 1);

  localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
  localparam logic [MEAN_BITS-1:0] MEAN_MAX = {MEAN_BITS{1'b1}};

  // Pixel token travelling down the cell chain
  typedef struct packed {
    logic                  valid;
    logic [GREEN_BITS-1:0] green;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  fend;
  } rgm_pix_t;

  // Captured frame total travelling back to the divider
  typedef struct packed {
    logic [SUM_BITS-1:0]  sum;
    logic [AREA_BITS-1:0] area;
  } rgm_cap_t;

  // Divider status seen by the controller
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 empty;
    logic [MEAN_BITS-1:0] mean;
  } rgm_div_status_t;

  // Frame coordinate from a stream position, cast to COORD_BITS
  function automatic logic [COORD_BITS-1:0] rgm_coord(input logic [PIX_POS_BITS-1:0] v);
    return COORD_BITS'(v);
  endfunction

  // Default window of region k: a 4 by 2 grid of 20 by 20 squares
  function automatic logic [WINDOW_BITS-1:0] rgm_window_reset(input int k);
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    x = COORD_BITS'(40 + 40 * (k & 3));
    y = COORD_BITS'(50 + 40 * (k >> 2));
    w = COORD_BITS'(20);
    return {x, y, w, w};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rgm_if.sv
// Channel interfaces: pixel stream, result stream and configuration writes.
`default_nettype none
interface rgm_pixel_if;
  logic                               valid;
  logic                               ready;
  logic [rgm_pkg::PIXEL_BITS-1:0]     pixel_value;
  logic [rgm_pkg::PIX_POS_BITS-1:0]   pixel_column;
  logic [rgm_pkg::PIX_POS_BITS-1:0]   pixel_row;
  logic                               frame_end;

  modport source (output valid, pixel_value, pixel_column, pixel_row, frame_end,
                  input ready);
  modport sink   (input valid, pixel_value, pixel_column, pixel_row, frame_end,
                  output ready);
endinterface

interface rgm_result_if;
  logic                            valid;
  logic                            ready;
  logic [rgm_pkg::REGION_BITS-1:0] region_index;
  logic [rgm_pkg::MEAN_BITS-1:0]   mean_green;
  logic                            empty_region;
  logic                            last_region;

  modport source (output valid, region_index, mean_green, empty_region, last_region,
                  input ready);
  modport sink   (input valid, region_index, mean_green, empty_region, last_region,
                  output ready);
endinterface

interface rgm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rgm_pkg::REG_IDX_BITS-1:0] index;
  logic [rgm_pkg::WINDOW_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/rgm_cell.sv
// One region cell: window register, running green sum, pixel and capture links.
`default_nettype none
module rgm_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [rgm_pkg::WINDOW_BITS-1:0] window_init,
  input  wire logic                            cfg_we,
  input  wire logic [rgm_pkg::WINDOW_BITS-1:0] cfg_data,
  input  wire rgm_pkg::rgm_pix_t               pix_in,
  output rgm_pkg::rgm_pix_t                    pix_out,
  input  wire logic                            shift,
  input  wire rgm_pkg::rgm_cap_t               cap_in,
  output rgm_pkg::rgm_cap_t                    cap_out
);
  import rgm_pkg::*;

  logic [WINDOW_BITS-1:0] window;
  logic [SUM_BITS-1:0]    sum;
  rgm_cap_t               cap;

  logic [COORD_BITS-1:0]  win_x, win_y, win_w, win_h;
  logic [COORD_BITS:0]    x_end, y_end;
  logic                   hit;
  logic [SUM_BITS:0]      sum_wide;
  logic [SUM_BITS-1:0]    sum_upd;
  logic [AREA_BITS-1:0]   area;

  assign {win_x, win_y, win_w, win_h} = window;

  // Containment test, end coordinates one bit wider so nothing wraps
  assign x_end = {1'b0, win_x} + {1'b0, win_w};
  assign y_end = {1'b0, win_y} + {1'b0, win_h};
  assign hit   = (pix_in.col >= win_x) && ({1'b0, pix_in.col} < x_end) &&
                 (pix_in.row >= win_y) && ({1'b0, pix_in.row} < y_end);

  // Saturating accumulate
  assign sum_wide = {1'b0, sum} + (SUM_BITS + 1)'(pix_in.green);
  always_comb begin
    sum_upd = sum;
    if (hit) begin
      sum_upd = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
    end
  end

  assign area = {{COORD_BITS{1'b0}}, win_w} * {{COORD_BITS{1'b0}}, win_h};

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= window_init;
    end else if (cfg_we) begin
      window <= cfg_data;
    end
  end

  // Running sum, cleared as the frame-end token passes
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (pix_in.valid) begin
      sum <= pix_in.fend ? '0 : sum_upd;
    end
  end

  // Capture slot: loaded at frame end, then shifted towards the divider
  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.fend) begin
      cap.sum  <= sum_upd;
      cap.area <= area;
    end else if (shift) begin
      cap <= cap_in;
    end
  end

  // Pixel link to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else begin
      pix_out.valid <= pix_in.valid;
    end
    pix_out.green <= pix_in.green;
    pix_out.col   <= pix_in.col;
    pix_out.row   <= pix_in.row;
    pix_out.fend  <= pix_in.fend;
  end

  assign cap_out = cap;

endmodule
`default_nettype wire

### hw/rtl/rgm_divider.sv
// Radix-2 restoring divider for sum * 2^FRAC / area with saturation.
`default_nettype none
module rgm_divider (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire rgm_pkg::rgm_cap_t      operand,
  output rgm_pkg::rgm_div_status_t    status
);
  import rgm_pkg::*;

  logic                  busy;
  logic                  done;
  logic                  fast;
  logic                  empty;
  logic [STEP_BITS-1:0]  cnt;
  logic [AREA_BITS-1:0]  divisor;
  logic [AREA_BITS-1:0]  rem;
  logic [MEAN_BITS-1:0]  low;
  logic [MEAN_BITS-1:0]  quo;

  logic [SUM_BITS-SAT_SHIFT-1:0] sum_hi;
  logic                          is_empty, is_sat;
  logic [AREA_BITS:0]            trial, diff;
  logic                          ge;

  // Quotient would reach 2^MEAN_BITS exactly when sum / 2^SAT_SHIFT >= area
  assign sum_hi   = operand.sum[SUM_BITS-1:SAT_SHIFT];
  assign is_empty = (operand.area == '0);
  assign is_sat   = (sum_hi >= operand.area);

  // One quotient bit per step
  assign trial = {rem, low[MEAN_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (fast || cnt == STEP_BITS'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= operand.area;
      empty   <= is_empty;
      fast    <= is_empty || is_sat;
      cnt     <= STEP_BITS'(MEAN_BITS);
      rem     <= AREA_BITS'(sum_hi);
      low     <= {operand.sum[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      quo     <= is_empty ? '0 : (is_sat ? MEAN_MAX : '0);
    end else if (busy && !fast) begin
      cnt <= cnt - STEP_BITS'(1);
      rem <= ge ? diff[AREA_BITS-1:0] : trial[AREA_BITS-1:0];
      low <= {low[MEAN_BITS-2:0], 1'b0};
      quo <= {quo[MEAN_BITS-2:0], ge};
    end
  end

  assign status.busy  = busy;
  assign status.done  = done;
  assign status.empty = empty;
  assign status.mean  = quo;

endmodule
`default_nettype wire

### hw/rtl/roi_green_mean.sv
// Top level: cell chain, frame-end controller, divider and result register.
`default_nettype none
// Per-region mean of the RGB565 green channel. Pixels enter a chain of
// NUM_REGIONS cells at one transfer per clock; each cell holds one region
// window and its saturating green sum and registers the pixel before
// passing it on. On the frame-end pixel the input stops: the token moves
// through the cell registers to leave the chain, each cell parking its
// total in a capture slot. The slots then shift one by one into a shared
// bit-serial divider, one quotient bit a cycle for 14 bits; an empty or
// saturated region skips the division, and a result may wait on the
// result side. Pixel transfers resume once the last result of the frame
// sits in the output register. Configuration writes take effect
// at once and are always accepted; write them only while the block is idle.
module roi_green_mean (
  input  wire logic   clk,
  input  wire logic   rst,
  rgm_cfg_if.sink     cfg,
  rgm_pixel_if.sink   pixel,
  rgm_result_if.source result
);
  import rgm_pkg::*;

  localparam logic [1:0] PH_RUN   = 2'd0;
  localparam logic [1:0] PH_DRAIN = 2'd1;
  localparam logic [1:0] PH_DIV   = 2'd2;

  logic [1:0]             phase;
  logic [REGION_BITS-1:0] rcnt;
  logic                   res_pend;
  logic                   out_valid;
  logic [REGION_BITS-1:0] out_index;
  logic [MEAN_BITS-1:0]   out_mean;
  logic                   out_empty;
  logic                   out_last;

  rgm_pix_t        pix_chain [0:NUM_REGIONS];
  rgm_cap_t        cap_chain [0:NUM_REGIONS];
  rgm_div_status_t div_st;

  logic pix_acc, out_acc, tail_fend, last_rc, load, div_start;

  assign cfg.ready   = 1'b1;
  assign pixel.ready = (phase == PH_RUN);
  assign pix_acc     = pixel.valid && pixel.ready;
  assign out_acc     = out_valid && result.ready;
  assign tail_fend   = pix_chain[NUM_REGIONS].valid && pix_chain[NUM_REGIONS].fend;
  assign last_rc     = (rcnt == REGION_BITS'(NUM_REGIONS - 1));
  assign load        = res_pend && (!out_valid || out_acc);
  assign div_start   = ((phase == PH_DRAIN) && tail_fend) ||
                       ((phase == PH_DIV) && load && !last_rc);

  // Head of the pixel chain
  assign pix_chain[0].valid = pix_acc;
  assign pix_chain[0].green = pixel.pixel_value[GREEN_SHIFT +: GREEN_BITS];
  assign pix_chain[0].col   = rgm_coord(pixel.pixel_column);
  assign pix_chain[0].row   = rgm_coord(pixel.pixel_row);
  assign pix_chain[0].fend  = pixel.frame_end;

  assign cap_chain[NUM_REGIONS] = '0;

  // Region cells
  for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
    logic we;
    assign we = cfg.valid && (cfg.index == REG_IDX_BITS'(i));
    rgm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .window_init (rgm_window_reset(i)),
      .cfg_we      (we),
      .cfg_data    (cfg.data),
      .pix_in      (pix_chain[i]),
      .pix_out     (pix_chain[i+1]),
      .shift       (div_start),
      .cap_in      (cap_chain[i+1]),
      .cap_out     (cap_chain[i])
    );
  end

  rgm_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .operand (cap_chain[0]),
    .status  (div_st)
  );

  // Frame-end sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RUN;
      rcnt     <= '0;
      res_pend <= 1'b0;
    end else begin
      if (div_st.done) begin
        res_pend <= 1'b1;
      end else if (load) begin
        res_pend <= 1'b0;
      end
      case (phase)
        PH_RUN: begin
          if (pix_acc && pixel.frame_end) begin
            phase <= PH_DRAIN;
          end
        end
        PH_DRAIN: begin
          if (tail_fend) begin
            phase <= PH_DIV;
            rcnt  <= '0;
          end
        end
        PH_DIV: begin
          if (load) begin
            rcnt <= rcnt + REGION_BITS'(1);
            if (last_rc) begin
              phase <= PH_RUN;
            end
          end
        end
        default: begin
          phase <= PH_RUN;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_index <= rcnt;
      out_mean  <= div_st.mean;
      out_empty <= div_st.empty;
      out_last  <= last_rc;
    end
  end

  assign result.valid        = out_valid;
  assign result.region_index = out_index;
  assign result.mean_green   = out_mean;
  assign result.empty_region = out_empty;
  assign result.last_region  = out_last;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> !res_pend)
    else $error("divider result overwritten before it was taken");

  a_tail_drain: assert property (@(posedge clk) disable iff (rst)
    tail_fend |-> (phase == PH_DRAIN))
    else $error("frame-end token left the chain outside drain");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == REGION_BITS'(NUM_REGIONS - 1))))
    else $error("last flag does not match region index");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_mean == '0))
    else $error("empty region with non-zero mean");

endmodule
`default_nettype wire
